@@ rtl/deq_pkg.sv @@
`default_nettype none

package deq_pkg;

    localparam int VALUE_W  = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    // operation codes on the kind field
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic                push_front;
        logic                push_rear;
        logic                pop_front;
        logic                pop_rear;
        logic                dump_start;
        logic                dump_read;
        logic                dump_step;
        logic                load_imm;
        logic                load_mem;
        logic [STATUS_W-1:0] load_status;
        logic                load_last;
    } deq_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic dump_last;
    } deq_stat_t;

endpackage

`default_nettype wire

@@ rtl/deq_ctrl.sv @@
`default_nettype none

module deq_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [deq_pkg::KIND_W-1:0]  kind,
    input  wire deq_pkg::deq_stat_t          stat,
    output deq_pkg::deq_cmd_t                cmd
);
    import deq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DREAD,
        S_DLOAD
    } state_t;

    state_t state_reg;
    state_t state_next;

    // new items only in idle, and only with room in the output register
    assign in_ready = (state_reg == S_IDLE) && stat.out_free;

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    unique case (kind)
                        KIND_PUSH_FRONT, KIND_PUSH_REAR:
                        begin
                            cmd.load_imm  = 1'b1;
                            cmd.load_last = 1'b1;
                            if (stat.full)
                            begin
                                cmd.load_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.load_status = ST_OK;
                                cmd.push_front  = (kind == KIND_PUSH_FRONT);
                                cmd.push_rear   = (kind == KIND_PUSH_REAR);
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_REAR:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_imm    = 1'b1;
                                cmd.load_status = ST_EMPTY;
                                cmd.load_last   = 1'b1;
                            end
                            else
                            begin
                                cmd.pop_front = (kind == KIND_POP_FRONT);
                                cmd.pop_rear  = (kind == KIND_POP_REAR);
                                state_next    = S_POP;
                            end
                        end
                        KIND_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_imm    = 1'b1;
                                cmd.load_status = ST_EMPTY;
                                cmd.load_last   = 1'b1;
                            end
                            else
                            begin
                                cmd.dump_start = 1'b1;
                                state_next     = S_DREAD;
                            end
                        end
                        default:
                        begin
                            // unused codes are dropped
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_mem    = 1'b1;
                    cmd.load_status = ST_OK;
                    cmd.load_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DREAD:
            begin
                cmd.dump_read = 1'b1;
                state_next    = S_DLOAD;
            end
            S_DLOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.load_mem    = 1'b1;
                    cmd.load_status = ST_OK;
                    cmd.load_last   = stat.dump_last;
                    if (stat.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.dump_step = 1'b1;
                        state_next    = S_DREAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/deq_dpath.sv @@
`default_nettype none

module deq_dpath #(
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire deq_pkg::deq_cmd_t                    cmd,
    output deq_pkg::deq_stat_t                        stat,
    input  wire logic signed [deq_pkg::VALUE_W-1:0]   push_value,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [deq_pkg::STATUS_W-1:0]              status,
    output logic signed [deq_pkg::VALUE_W-1:0]        out_value,
    output logic                                      last
);
    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT   = CW'(1);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_SLOT : p - AW'(1);
    endfunction

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    logic [AW-1:0] head_reg;
    logic [AW-1:0] tail_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] idx_reg;
    logic [CW-1:0] rem_reg;
    logic          out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic                last_reg;

    logic [AW-1:0] head_dec;
    logic [AW-1:0] tail_dec;
    logic          we;
    logic [AW-1:0] waddr;
    logic          re;
    logic [AW-1:0] raddr;

    assign head_dec = wrap_dec(head_reg);
    assign tail_dec = wrap_dec(tail_reg);

    // store port addresses
    assign we    = cmd.push_front | cmd.push_rear;
    assign waddr = cmd.push_front ? head_dec : tail_reg;
    assign re    = cmd.pop_front | cmd.pop_rear | cmd.dump_read;

    always_comb
    begin
        priority if (cmd.pop_front)
        begin
            raddr = head_reg;
        end
        else if (cmd.pop_rear)
        begin
            raddr = tail_dec;
        end
        else
        begin
            raddr = idx_reg;
        end
    end

    // entry store, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= push_value;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // pointers, occupancy and dump walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            if (cmd.push_front)
            begin
                head_reg <= head_dec;
            end
            else if (cmd.pop_front)
            begin
                head_reg <= wrap_inc(head_reg);
            end
            if (cmd.push_rear)
            begin
                tail_reg <= wrap_inc(tail_reg);
            end
            else if (cmd.pop_rear)
            begin
                tail_reg <= tail_dec;
            end
            if (cmd.push_front || cmd.push_rear)
            begin
                count_reg <= count_reg + ONE_CNT;
            end
            else if (cmd.pop_front || cmd.pop_rear)
            begin
                count_reg <= count_reg - ONE_CNT;
            end
            if (cmd.dump_start)
            begin
                idx_reg <= head_reg;
                rem_reg <= count_reg;
            end
            else if (cmd.dump_step)
            begin
                idx_reg <= wrap_inc(idx_reg);
                rem_reg <= rem_reg - ONE_CNT;
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_imm || cmd.load_mem)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_imm || cmd.load_mem)
        begin
            status_reg <= cmd.load_status;
            last_reg   <= cmd.load_last;
            value_reg  <= cmd.load_mem ? rdata_reg : '0;
        end
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == FULL_CNT);
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.dump_last = (rem_reg == ONE_CNT);

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_value = value_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

@@ rtl/double_ended_queue.sv @@
// push, refused push and any empty result: output register loaded at the accepting edge
// pop: registered store read, loaded in S_POP once the output is free, then next item taken
// dump of n entries: each read, then loaded once free; input held off until the last
// output register holds one result, so input is taken while it drains if out_ready is high
// reset clears head, tail, occupancy, the controller state and output valid; the store is
// left as is and only entries that were written are ever read
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [deq_pkg::KIND_W-1:0]           kind,
    input  wire logic signed [deq_pkg::VALUE_W-1:0]   push_value,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [deq_pkg::STATUS_W-1:0]              status,
    output logic signed [deq_pkg::VALUE_W-1:0]        out_value,
    output logic                                      last
);
    import deq_pkg::*;

    deq_cmd_t  cmd;
    deq_stat_t stat;

    // sequencing
    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, pointers and output register
    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .out_value  (out_value),
        .last       (last)
    );

    // queue cannot be empty and full at once
    a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.empty && stat.full))
        else $error("queue flagged empty and full together");

    // an item is only taken when the output register can hold its result
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!out_valid || out_ready))
        else $error("input taken with output register occupied");

    // every accepted push answers in the next cycle
    a_push_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_REAR))
        |=> out_valid)
        else $error("push result missing");

    // a pop that finds entries blocks input while its read is in flight
    a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !stat.empty &&
         (kind == KIND_POP_FRONT || kind == KIND_POP_REAR))
        |=> !in_ready)
        else $error("input taken during pop read");

endmodule

`default_nettype wire
